// ----- design/lru_key_cache_assert.svh -----
// Assertion macros shared by the cache RTL.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef LRU_KEY_CACHE_ASSERT_SVH
`define LRU_KEY_CACHE_ASSERT_SVH

// Same-cycle implication
`define LKC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication
`define LKC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lkc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lkc_pkg;

  // Default sizing
  localparam int LKC_MAX_ENTRIES = 64;
  localparam int LKC_KEY_BITS    = 32;

  // Field widths of the transfers
  localparam int LKC_KEY_W = 32;
  localparam int LKC_CAP_W = 7;

  // Position/count width inside the control struct, covers up to 2047 entries
  localparam int LKC_IDX_W = 11;

  // Item kinds
  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [LKC_KEY_W-1:0] key;
  } lkc_req_t;

  typedef struct packed {
    logic                 hit;
    logic                 evicted_valid;
    logic [LKC_KEY_W-1:0] evicted_key;
  } lkc_res_t;

  // Control broadcast along the cell row
  typedef struct packed {
    logic                 cmp;    // compare stored key against op key
    logic                 shift;  // update phase: cells up to limit take their neighbor
    logic [LKC_IDX_W-1:0] limit;  // last position that takes a new key
    logic [LKC_IDX_W-1:0] occ;    // number of valid positions
    logic [LKC_IDX_W-1:0] tail;   // position of the least recent key
  } lkc_cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/lkc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One position of the recency chain: holds a key, compares it against the
// broadcast op key, and takes its neighbor's key when the row shifts.
module lkc_cell
  import lkc_pkg::*;
#(
  parameter int INDEX    = 0,
  parameter int KEY_BITS = LKC_KEY_BITS
) (
  input  wire logic                clk_i,
  input  wire lkc_cell_ctrl_t      ctrl_i,
  input  wire logic [KEY_BITS-1:0] op_key_i,
  input  wire logic [KEY_BITS-1:0] prev_key_i,
  output logic      [KEY_BITS-1:0] key_o,
  output logic                     match_o,
  output logic      [KEY_BITS-1:0] tail_key_o
);

  localparam logic [LKC_IDX_W-1:0] MyIdx = LKC_IDX_W'(INDEX);

  logic [KEY_BITS-1:0] key_q;
  logic                match_q;
  logic                valid;

  assign valid = (MyIdx < ctrl_i.occ);

  // Match flag, taken in the compare cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp) begin
      match_q <= valid && (key_q == op_key_i);
    end
  end

  // Shift toward the least recent end
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift && (MyIdx <= ctrl_i.limit)) begin
      key_q <= prev_key_i;
    end
  end

  assign key_o      = key_q;
  assign match_o    = match_q;
  assign tail_key_o = (MyIdx == ctrl_i.tail) ? key_q : '0;

endmodule

`default_nettype wire

// ----- design/lru_key_cache.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel    Ports                         Transfer
// request    start, busy, req_i            start high and busy low at clk_i rise
// result     res_valid_o, res_o            res_valid_o high for one cycle
// config     cfg_we_i, cfg_wdata_i         cfg_we_i high at clk_i rise
//
// Each item passes a compare cycle across the cell row, then an update
// cycle in which the row shifts. busy is high only in the compare cycle,
// so a new request can be taken in the update cycle. The result is on the
// ports in the cycle after the update.
// Reset empties the cache (occupancy zero) and sets capacity to zero; the key
// cells keep no reset and need no clearing pass. The receiver cannot stall.
module lru_key_cache
  import lkc_pkg::*;
#(
  parameter int MAX_ENTRIES = LKC_MAX_ENTRIES,
  parameter int KEY_BITS    = LKC_KEY_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire lkc_req_t             req_i,
  output logic                      res_valid_o,
  output lkc_res_t                  res_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [LKC_CAP_W-1:0] cfg_wdata_i
);

  `include "lru_key_cache_assert.svh"

  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (OCC_W > LKC_CAP_W) ? OCC_W : LKC_CAP_W;
  localparam int KEY_W = (KEY_BITS > LKC_KEY_W) ? KEY_BITS : LKC_KEY_W;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_e;

  state_e               state_q;
  logic [OCC_W-1:0]     occ_q;
  logic [LKC_CAP_W-1:0] cap_q;
  logic                 res_valid_q;
  lkc_res_t             res_q;

  logic                 op_kind_q;
  logic [KEY_BITS-1:0]  op_key_q;

  logic                 accept;
  logic [KEY_W-1:0]     in_key_wide;
  lkc_cell_ctrl_t       ctrl;

  logic [MAX_ENTRIES-1:0] match;
  logic [KEY_BITS-1:0]    cell_key  [MAX_ENTRIES];
  logic [KEY_BITS-1:0]    tail_key  [MAX_ENTRIES];
  logic [KEY_BITS-1:0]    prev_key  [MAX_ENTRIES];

  logic [LKC_IDX_W-1:0] hit_idx;
  logic [KEY_BITS-1:0]  tail_or;
  logic [KEY_W-1:0]     ev_wide;
  logic [CMP_W-1:0]     cap_eff;
  logic [CMP_W-1:0]     occ_cmp;
  logic [LKC_IDX_W-1:0] occ_idx;
  logic                 enabled;
  logic                 is_clear;
  logic                 hit;
  logic                 full;
  logic                 evict;
  logic [OCC_W-1:0]     occ_d;
  lkc_res_t             res_d;

  assign busy   = (state_q == S_CMP);
  assign accept = start && !busy;

  // Op registers, loaded on each request transfer
  assign in_key_wide = KEY_W'(req_i.key);
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_kind_q <= req_i.kind;
      op_key_q  <= in_key_wide[KEY_BITS-1:0];
    end
  end

  // Decode of the update cycle
  assign occ_idx  = LKC_IDX_W'(occ_q);
  assign occ_cmp  = CMP_W'(occ_q);
  assign cap_eff  = (CMP_W'(cap_q) > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES)
                                                         : CMP_W'(cap_q);
  assign enabled  = (cap_eff != '0);
  assign is_clear = (op_kind_q == KIND_CLEAR);
  assign hit      = enabled && !is_clear && (|match);
  assign full     = (occ_cmp >= cap_eff);
  assign evict    = enabled && !is_clear && !hit && full;

  // Position of the matching cell; at most one cell matches
  always_comb begin
    hit_idx = '0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      hit_idx = hit_idx | (match[j] ? LKC_IDX_W'(j) : '0);
    end
  end

  // Least recent key, picked by the tail cell
  always_comb begin
    tail_or = '0;
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      tail_or = tail_or | tail_key[j];
    end
  end
  assign ev_wide = KEY_W'(tail_or);

  // Row control
  always_comb begin
    ctrl.cmp   = (state_q == S_CMP);
    ctrl.shift = (state_q == S_UPD) && enabled && !is_clear;
    ctrl.occ   = occ_idx;
    ctrl.tail  = occ_idx - LKC_IDX_W'(1);
    if (hit) begin
      ctrl.limit = hit_idx;
    end else if (evict) begin
      ctrl.limit = occ_idx - LKC_IDX_W'(1);
    end else begin
      ctrl.limit = occ_idx;
    end
  end

  // Next occupancy and result
  always_comb begin
    occ_d = occ_q;
    if (is_clear) begin
      occ_d = '0;
    end else if (enabled && !hit && !full) begin
      occ_d = occ_q + OCC_W'(1);
    end
    res_d.hit           = hit;
    res_d.evicted_valid = evict;
    res_d.evicted_key   = evict ? ev_wide[LKC_KEY_W-1:0] : '0;
  end

  // Sequencer, occupancy, capacity and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      cap_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= (state_q == S_UPD);
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          occ_q   <= occ_d;
          res_q   <= res_d;
          state_q <= accept ? S_CMP : S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Cell row: cell 0 takes the op key, every other cell its neighbor's key
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prev_key[g] = op_key_q;
    end else begin : g_body
      assign prev_key[g] = cell_key[g-1];
    end
    lkc_cell #(
      .INDEX    (g),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .op_key_i   (op_key_q),
      .prev_key_i (prev_key[g]),
      .key_o      (cell_key[g]),
      .match_o    (match[g]),
      .tail_key_o (tail_key[g])
    );
  end

  // Checks
  `LKC_ASSERT_IMP(a_single_match, state_q == S_UPD, $onehot0(match),
                  "more than one cell holds the key")
  `LKC_ASSERT_IMP(a_result_timing, accept, ##3 res_valid_o,
                  "no result three cycles after a request transfer")
  `LKC_ASSERT_IMP(a_hit_no_evict, res_valid_o, !(res_o.hit && res_o.evicted_valid),
                  "hit reported together with an eviction")
  `LKC_ASSERT_NXT(a_occ_grows, state_q == S_UPD && !is_clear, occ_q >= $past(occ_q),
                  "occupancy dropped on an access")

endmodule

`default_nettype wire

// ----- tb/sv/lru_key_cache_checker.sv -----
`timescale 1ns / 1ps

// Watches the request, result and config channels of lru_key_cache, keeps
// its own LRU recency list and compares every result against it.
module lru_key_cache_checker
  import lkc_pkg::*;
#(
  parameter int MAX_ENTRIES = LKC_MAX_ENTRIES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  lkc_req_t             req_i,
  input  logic                 res_valid_i,
  input  lkc_res_t             res_i,
  input  logic                 cfg_we_i,
  input  logic [LKC_CAP_W-1:0] cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  // Recency list: position 0 is the most recent key
  logic [LKC_KEY_W-1:0] recency_list [MAX_ENTRIES];
  int unsigned          occupancy;
  logic [LKC_CAP_W-1:0] capacity_q;

  // Lookup outcomes still waiting for their result transfer
  lkc_res_t lookup_outcomes [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] lru_key_cache mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  // Shift positions [0, upto) one toward the tail, then put k at the head
  function automatic void promote_key(input int unsigned upto,
                                      input logic [LKC_KEY_W-1:0] k);
    for (int i = upto; i > 0; i--) begin
      if (i < MAX_ENTRIES) recency_list[i] = recency_list[i-1];
    end
    recency_list[0] = k;
  endfunction

  // One access or clear against the recency list
  function automatic lkc_res_t lru_access(input lkc_req_t r);
    lkc_res_t    o;
    int unsigned lim;
    int unsigned pos;
    o   = '0;
    lim = (capacity_q > MAX_ENTRIES) ? MAX_ENTRIES : capacity_q;
    if (occupancy > MAX_ENTRIES) occupancy = MAX_ENTRIES;
    if (r.kind == KIND_CLEAR) begin
      occupancy = 0;
    end else if (lim != 0) begin
      pos = occupancy;
      for (int i = 0; i < occupancy; i++) begin
        if (pos == occupancy && recency_list[i] == r.key) pos = i;
      end
      if (pos < occupancy) begin
        o.hit = 1'b1;
        promote_key(pos, r.key);
      end else begin
        // full (or over capacity after a lowering): drop the tail first
        if (occupancy >= lim && occupancy > 0) begin
          o.evicted_valid = 1'b1;
          o.evicted_key   = recency_list[occupancy-1];
          occupancy--;
        end
        promote_key(occupancy, r.key);
        if (occupancy < MAX_ENTRIES) occupancy++;
      end
    end
    return o;
  endfunction

  // Channel monitor: compare the oldest outcome first, then queue the new one
  always @(posedge clk_i or negedge rst_ni) begin
    lkc_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ENTRIES; i++) recency_list[i] = '0;
      occupancy    = 0;
      capacity_q   = '0;
      lookup_outcomes.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) capacity_q = cfg_wdata_i;
      if (res_valid_i) begin
        if (lookup_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding (hit=%0b ev=%0b/%h)",
                                    res_i.hit, res_i.evicted_valid, res_i.evicted_key));
        end else begin
          want = lookup_outcomes.pop_front();
          if (res_i.hit !== want.hit)
            report_mismatch($sformatf("hit got %b want %b", res_i.hit, want.hit));
          if (res_i.evicted_valid !== want.evicted_valid)
            report_mismatch($sformatf("evicted_valid got %b want %b",
                                      res_i.evicted_valid, want.evicted_valid));
          if (res_i.evicted_key !== want.evicted_key)
            report_mismatch($sformatf("evicted_key got %h want %h",
                                      res_i.evicted_key, want.evicted_key));
        end
      end
      if (start_i && !busy_i) lookup_outcomes.push_back(lru_access(req_i));
      pending_o = lookup_outcomes.size();
    end
  end

endmodule

// ----- tb/sv/lru_key_cache_tb.sv -----
`timescale 1ns / 1ps

// Drives lru_key_cache through a directed sweep of the corner cases and then
// randomized access streams over several capacities; the checker predicts.
module lru_key_cache_tb;
  import lkc_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 244;
  localparam int DRAIN_CYCLES    = 4;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  lkc_req_t             req;
  logic                 res_valid;
  lkc_res_t             res;
  logic                 cfg_we;
  logic [LKC_CAP_W-1:0] cfg_wdata;
  int                   fail_count;
  int                   pending;
  int                   quiet_cycles;

  lru_key_cache DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_o       (res),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  lru_key_cache_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: too long without any transfer on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid || cfg_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Lower start and wait until every outstanding lookup has reported back
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [LKC_CAP_W-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // One request transfer, preceded by random idle cycles
  task automatic send_item(input logic kind, input logic [LKC_KEY_W-1:0] key,
                           input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start    <= 1'b1;
    req.kind <= kind;
    req.key  <= key;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    logic [LKC_CAP_W-1:0] phase_caps [N_PHASES];
    logic [LKC_KEY_W-1:0] key_pool [128];
    logic [LKC_KEY_W-1:0] last_key;
    logic [LKC_KEY_W-1:0] k;
    logic                 kind;
    int                   eff_cap;
    int                   pool_n;
    int                   sent;
    int                   roll;
    int                   idle_pct;

    rst_ni       = 1'b0;
    start        = 1'b0;
    req          = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    quiet_cycles = 0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: disabled cache out of reset, clear item ignores its key
    send_item(KIND_ACCESS, 32'h0000_0000, 0);
    send_item(KIND_CLEAR,  32'hFFFF_FFFF, 0);

    // Two entries: fill, hit, evict twice, clear, refill
    write_capacity(7'd2);
    send_item(KIND_ACCESS, 32'h0000_0000, 0);
    send_item(KIND_ACCESS, 32'hFFFF_FFFF, 0);
    send_item(KIND_ACCESS, 32'h0000_0000, 0);
    send_item(KIND_ACCESS, 32'h1234_5678, 0);
    send_item(KIND_ACCESS, 32'hFFFF_FFFF, 0);
    send_item(KIND_CLEAR,  32'h0000_0000, 0);
    send_item(KIND_ACCESS, 32'h0000_0000, 0);

    // Grow to three, then lower capacity below occupancy
    write_capacity(7'd3);
    send_item(KIND_ACCESS, 32'hFFFF_FFFF, 0);
    send_item(KIND_ACCESS, 32'h1234_5678, 0);
    write_capacity(7'd1);
    send_item(KIND_ACCESS, 32'hA5A5_5A5A, 0);
    send_item(KIND_ACCESS, 32'h1234_5678, 0);
    send_item(KIND_ACCESS, 32'h8000_0001, 0);

    // Disabled with keys stored, then capacity above the store size
    write_capacity(7'd0);
    send_item(KIND_ACCESS, 32'h1234_5678, 0);
    send_item(KIND_ACCESS, 32'h7FFF_FFFE, 0);
    write_capacity(7'd127);
    send_item(KIND_ACCESS, 32'h1234_5678, 0);
    send_item(KIND_ACCESS, 32'h7FFF_FFFE, 0);
    send_item(KIND_ACCESS, 32'h8000_0001, 0);

    // Random streams: mostly keys from a pool a bit larger than the capacity
    phase_caps = '{7'd64, 7'd127, 7'd7, 7'd1, 7'd0, 7'd33, 7'd2, 7'd16};
    sent     = 0;
    last_key = '0;
    for (int p = 0; p < N_PHASES; p++) begin
      write_capacity(phase_caps[p]);
      eff_cap = (phase_caps[p] > LKC_MAX_ENTRIES) ? LKC_MAX_ENTRIES : phase_caps[p];
      pool_n  = eff_cap + eff_cap / 2 + 2;
      for (int j = 0; j < pool_n; j++) key_pool[j] = $urandom;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        idle_pct = (sent < 650) ? 37 : (sent < 1300) ? 73 : 0;
        roll     = $urandom_range(99);
        kind     = KIND_ACCESS;
        if (roll < 3) begin
          kind = KIND_CLEAR;
          k    = $urandom;
        end else if (roll < 15) begin
          k = $urandom;
        end else if (roll < 28) begin
          k = last_key;
        end else begin
          k = key_pool[$urandom_range(pool_n - 1)];
        end
        if (kind == KIND_ACCESS) last_key = k;
        // occasional hold-off until the cache has answered everything
        if ($urandom_range(99) == 0) drain();
        send_item(kind, k, idle_pct);
        sent++;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
